>>> hdl/nhss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nhss_pkg - shared definitions for the name hash shard selector
//
// Widths, fixed constants of the Pearson hash, register indices and the
// request struct that drives the permutation RAM.
// ----------------------------------------------------------------------------
package nhss_pkg;

  // Hash and table geometry
  localparam int HASH_W      = 8;
  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = 8;

  // Configuration port
  localparam int CFG_W       = 16;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_CLUSTER_SIZE  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_CLUSTER_INDEX = CFG_INDEX_W'(1);

  localparam logic [CFG_W-1:0] CLUSTER_SIZE_RESET  = CFG_W'(1);
  localparam logic [CFG_W-1:0] CLUSTER_INDEX_RESET = CFG_W'(0);

  // Hash seed and shuffle key
  localparam logic [HASH_W-1:0] SEED_BASE = HASH_W'(123);
  localparam logic [HASH_W-1:0] KEY_START = HASH_W'(7);

  // Shuffle passes over the table
  localparam int SHUFFLE_PASSES = 4;
  localparam int PASS_W         = 2;

  // Remainder unit: one dividend bit per cycle
  localparam int REM_STEPS = HASH_W;
  localparam int STEP_W    = 3;

  // One cycle's worth of RAM access
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [HASH_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage
`default_nettype wire

>>> hdl/nhss_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nhss_ram - generic simple dual-port RAM
//
// One write port, one read port, read data registered and held while the
// read enable is low.
// ----------------------------------------------------------------------------
module nhss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> hdl/nhss_perm_build.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nhss_perm_build - permutation table builder
//
// After reset, writes the identity into the table, then runs the keyed
// shuffle: four passes over all entries, each step reading the entry,
// advancing the key by it and swapping the entry with the one at the key.
// A step reads the entry, then the entry at the new key, and writes both back.
// ----------------------------------------------------------------------------
module nhss_perm_build (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [nhss_pkg::HASH_W-1:0] rdata,
  output nhss_pkg::ram_req_t            req,
  output logic                          done
);

  import nhss_pkg::*;

  typedef enum logic [5:0] {
    B_FILL   = 6'b000001,
    B_RD_POS = 6'b000010,
    B_RD_KEY = 6'b000100,
    B_WR_POS = 6'b001000,
    B_WR_KEY = 6'b010000,
    B_DONE   = 6'b100000
  } build_state_t;

  build_state_t      state;
  logic [ADDR_W-1:0] pos;
  logic [HASH_W-1:0] key;
  logic [HASH_W-1:0] held;
  logic [PASS_W-1:0] pass;
  logic [HASH_W-1:0] key_sum;

  localparam logic [ADDR_W-1:0] POS_LAST  = ADDR_W'(TABLE_DEPTH - 1);
  localparam logic [PASS_W-1:0] PASS_LAST = PASS_W'(SHUFFLE_PASSES - 1);

  // Key advances by the entry just read (wraps mod 256)
  assign key_sum = key + rdata;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_FILL;
      pos   <= '0;
      key   <= KEY_START;
      pass  <= '0;
    end else begin
      case (state)
        B_FILL: begin
          pos <= pos + 1'b1;
          if (pos == POS_LAST) begin
            state <= B_RD_POS;
          end
        end
        B_RD_POS: begin
          state <= B_RD_KEY;
        end
        B_RD_KEY: begin
          key   <= key_sum;
          state <= B_WR_POS;
        end
        B_WR_POS: begin
          state <= B_WR_KEY;
        end
        B_WR_KEY: begin
          pos <= pos + 1'b1;
          if (pos == POS_LAST) begin
            pass <= pass + 1'b1;
            if (pass == PASS_LAST) begin
              state <= B_DONE;
            end else begin
              state <= B_RD_POS;
            end
          end else begin
            state <= B_RD_POS;
          end
        end
        B_DONE: begin
          state <= B_DONE;
        end
        default: begin
          state <= B_FILL;
        end
      endcase
    end
  end

  // Entry under the cursor, kept for the second half of the swap
  always_ff @(posedge clk) begin
    if (state == B_RD_KEY) begin
      held <= rdata;
    end
  end

  // RAM access per state
  always_comb begin
    req = '0;
    case (state)
      B_FILL: begin
        req.we    = 1'b1;
        req.waddr = pos;
        req.wdata = pos;
      end
      B_RD_POS: begin
        req.re    = 1'b1;
        req.raddr = pos;
      end
      B_RD_KEY: begin
        req.re    = 1'b1;
        req.raddr = key_sum;
      end
      B_WR_POS: begin
        req.we    = 1'b1;
        req.waddr = pos;
        req.wdata = rdata;
      end
      B_WR_KEY: begin
        req.we    = 1'b1;
        req.waddr = key;
        req.wdata = held;
      end
      default: begin
        req = '0;
      end
    endcase
  end

  assign done = (state == B_DONE);

endmodule
`default_nettype wire

>>> hdl/nhss_rem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nhss_rem - iterative remainder unit
//
// Restoring division of the eight-bit hash by the cluster size, one dividend
// bit per cycle. Only the remainder is kept.
// ----------------------------------------------------------------------------
module nhss_rem (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [nhss_pkg::HASH_W-1:0]   dividend,
  input  wire logic [nhss_pkg::CFG_W-1:0]    divisor,
  output logic                               done,
  output logic      [nhss_pkg::CFG_W-1:0]    rem
);

  import nhss_pkg::*;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(REM_STEPS - 1);

  logic              busy;
  logic [STEP_W-1:0] cnt;
  logic [HASH_W-1:0] quo;
  logic [CFG_W:0]    trial;
  logic [CFG_W:0]    diff;
  logic [CFG_W-1:0]  rem_next;

  // Shift in the next dividend bit, subtract when it fits
  always_comb begin
    trial    = {rem, quo[HASH_W-1]};
    diff     = trial - {1'b0, divisor};
    rem_next = (trial >= {1'b0, divisor}) ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == STEP_LAST) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[HASH_W-2:0], 1'b0};
    end
  end

  // High in the final step; rem is final on the next cycle
  assign done = busy && (cnt == STEP_LAST);

endmodule
`default_nettype wire

>>> hdl/name_hash_shard_select.sv
`default_nettype none
// ----------------------------------------------------------------------------
// name_hash_shard_select - Pearson hash of a name and shard ownership check
//
// Takes a name one byte per transaction and hashes it with an eight-bit
// Pearson hash; on the last byte it returns the hash and whether hash mod
// cluster_size equals cluster_index; a zero cluster_size never owns.
// ----------------------------------------------------------------------------
// After reset the permutation table is built in RAM: the identity fill of
// all 256 entries, then four shuffle passes over them. in_ready stays low
// until the build is done and the RAM is handed over (configuration writes
// are taken throughout). Afterwards an item that carries no byte and is not
// last leaves the block idle; a byte that is not last adds the registered
// table read on the single RAM port. A last item also runs through the
// bit-serial remainder unit and then loads the output register. The output
// register holds a result while the next name is taken in; a following
// result waits in the output state, with in_ready low, until the previous
// one is taken.
// ----------------------------------------------------------------------------
module name_hash_shard_select (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration
  input  wire logic                              cfg_we,
  input  wire logic [nhss_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [nhss_pkg::CFG_W-1:0]        cfg_data,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [nhss_pkg::HASH_W-1:0]       name_byte,
  input  wire logic [nhss_pkg::HASH_W-1:0]       length_mod,
  input  wire logic                              is_first,
  input  wire logic                              is_last,
  input  wire logic                              is_empty,
  // output channel
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [nhss_pkg::HASH_W-1:0]       hash_value,
  output logic                                   owned_here
);

  import nhss_pkg::*;

  typedef enum logic [4:0] {
    S_BUILD  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_LOOKUP = 5'b00100,
    S_MOD    = 5'b01000,
    S_OUT    = 5'b10000
  } state_t;

  state_t            state;
  logic [HASH_W-1:0] running_hash;
  logic              last_q;
  logic [CFG_W-1:0]  cluster_size;
  logic [CFG_W-1:0]  cluster_index;

  logic              accept;
  logic [HASH_W-1:0] seed;
  logic [HASH_W-1:0] lookup_addr;
  ram_req_t          build_req;
  ram_req_t          ram_req;
  logic              build_done;
  logic [HASH_W-1:0] ram_rdata;
  logic              mod_start;
  logic [HASH_W-1:0] mod_dividend;
  logic              mod_done;
  logic [CFG_W-1:0]  mod_rem;
  logic              out_load;
  logic              owned_calc;

  // Permutation table
  nhss_ram #(
    .WIDTH (HASH_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // Table builder, owns the RAM until done
  nhss_perm_build u_build (
    .clk   (clk),
    .rst   (rst),
    .rdata (ram_rdata),
    .req   (build_req),
    .done  (build_done)
  );

  // Remainder unit
  nhss_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (mod_dividend),
    .divisor  (cluster_size),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // Input handshake and seed selection
  assign in_ready    = (state == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign seed        = is_first ? (SEED_BASE + length_mod) : running_hash;
  assign lookup_addr = seed + name_byte;

  // RAM port: builder first, hash lookups afterwards
  always_comb begin
    if (state == S_BUILD) begin
      ram_req = build_req;
    end else begin
      ram_req       = '0;
      ram_req.re    = accept && !is_empty;
      ram_req.raddr = lookup_addr;
    end
  end

  // Remainder start: empty last item uses the seed, otherwise the lookup
  assign mod_start    = (accept && is_empty && is_last) || (state == S_LOOKUP && last_q);
  assign mod_dividend = (state == S_LOOKUP) ? ram_rdata : seed;

  assign out_load   = (state == S_OUT) && (!out_valid || out_ready);
  assign owned_calc = (cluster_size != '0) && (mod_rem == cluster_index);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_size  <= CLUSTER_SIZE_RESET;
      cluster_index <= CLUSTER_INDEX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CLUSTER_SIZE:  cluster_size  <= cfg_data;
        REG_CLUSTER_INDEX: cluster_index <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer and running hash
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_BUILD;
      running_hash <= '0;
      last_q       <= 1'b0;
    end else begin
      case (state)
        S_BUILD: begin
          if (build_done) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            last_q <= is_last;
            if (!is_empty) begin
              state <= S_LOOKUP;
            end else begin
              running_hash <= seed;
              if (is_last) begin
                state <= S_MOD;
              end
            end
          end
        end
        S_LOOKUP: begin
          running_hash <= ram_rdata;
          state        <= last_q ? S_MOD : S_IDLE;
        end
        S_MOD: begin
          if (mod_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_BUILD;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      hash_value <= running_hash;
      owned_here <= owned_calc;
    end
  end

endmodule
`default_nettype wire

>>> hdl/nhss_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nhss_checker - port-level assertions for the shard selector
//
// Watches the top level's ports only; bound to every instance of it.
// ----------------------------------------------------------------------------
module nhss_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              cfg_we,
  input wire logic [nhss_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input wire logic [nhss_pkg::CFG_W-1:0]        cfg_data,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic [nhss_pkg::HASH_W-1:0]       name_byte,
  input wire logic [nhss_pkg::HASH_W-1:0]       length_mod,
  input wire logic                              is_first,
  input wire logic                              is_last,
  input wire logic                              is_empty,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [nhss_pkg::HASH_W-1:0]       hash_value,
  input wire logic                              owned_here
);

  // Table build follows reset: nothing taken in, nothing offered
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !in_ready && !out_valid)
    else $error("block active straight after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hash_value) && $stable(owned_here))
    else $error("result changed or dropped while stalled");

  // A byte needs a table read, so the block is busy next cycle
  a_byte_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !is_empty |=> !in_ready)
    else $error("byte transaction did not occupy the lookup");

  // A last item always goes through the remainder unit
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && is_last |=> !in_ready && !(out_valid && $rose(out_valid)))
    else $error("last transaction did not start the remainder");

endmodule

bind name_hash_shard_select nhss_checker u_nhss_checker (.*);
`default_nettype wire

>>> verif/name_hash_shard_select_checker.sv
// ----------------------------------------------------------------------------
// name_hash_shard_select_checker - scoreboard for the name hash shard selector
//
// Watches the configuration port and both channels, keeps its own copy of the
// shuffled permutation, the running hash and the cluster settings, predicts
// the digest of every finished name and compares each returned transaction
// with the oldest prediction. Channels are sampled on the falling edge, so
// a transaction seen here is the one the block takes at the next rising edge.
// ----------------------------------------------------------------------------
module name_hash_shard_select_checker
  import nhss_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_data,
  input  wire logic                   in_valid,
  input  wire logic                   in_ready,
  input  wire logic [HASH_W-1:0]      name_byte,
  input  wire logic [HASH_W-1:0]      length_mod,
  input  wire logic                   is_first,
  input  wire logic                   is_last,
  input  wire logic                   is_empty,
  input  wire logic                   out_valid,
  input  wire logic                   out_ready,
  input  wire logic [HASH_W-1:0]      hash_value,
  input  wire logic                   owned_here,
  output int                          mismatches,
  output int                          outstanding
);

  typedef struct packed {
    logic [HASH_W-1:0] hash_byte;
    logic              owned;
  } digest_t;

  logic [HASH_W-1:0] perm [TABLE_DEPTH];
  logic [HASH_W-1:0] chain_hash;
  logic [CFG_W-1:0]  shard_count;
  logic [CFG_W-1:0]  shard_slot;
  digest_t           due_digests [$];

  // Identity table shuffled by the key passes
  function automatic void shuffle_table();
    int                key;
    logic [HASH_W-1:0] held;
    key = KEY_START;
    for (int i = 0; i < TABLE_DEPTH; i++) perm[i] = HASH_W'(i);
    for (int p = 0; p < SHUFFLE_PASSES; p++) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        held    = perm[i];
        key     = (key + held) % TABLE_DEPTH;
        perm[i] = perm[key];
        perm[key] = held;
      end
    end
  endfunction

  initial shuffle_table();

  // Running hash after one byte transaction
  function automatic logic [HASH_W-1:0] next_chain_hash(
    input logic [HASH_W-1:0] prev,
    input logic [HASH_W-1:0] b,
    input logic [HASH_W-1:0] len,
    input logic              first,
    input logic              empty
  );
    logic [HASH_W-1:0] h;
    logic [HASH_W-1:0] sum;
    h = prev;
    if (first) h = SEED_BASE + len;
    if (!empty) begin
      sum = h + b;
      h   = perm[sum];
    end
    return h;
  endfunction

  // Zero cluster size never owns; an index beyond the size never matches
  function automatic logic owns_shard(input logic [HASH_W-1:0] h);
    return (shard_count != '0) && ((CFG_W'(h) % shard_count) == shard_slot);
  endfunction

  always @(negedge clk) begin
    digest_t want;
    if (rst) begin
      chain_hash  = '0;
      shard_count = CLUSTER_SIZE_RESET;
      shard_slot  = CLUSTER_INDEX_RESET;
      due_digests.delete();
    end else begin
      // register writes; unknown indices fall through
      if (cfg_we) begin
        if (cfg_index == REG_CLUSTER_SIZE) shard_count = cfg_data;
        else if (cfg_index == REG_CLUSTER_INDEX) shard_slot = cfg_data;
      end

      // returned digest against the oldest prediction
      if (out_valid && out_ready) begin
        if (due_digests.size() == 0) begin
          $error("unexpected result: hash_value %0d owned_here %0b", hash_value, owned_here);
          mismatches++;
        end else begin
          want = due_digests.pop_front();
          if (hash_value !== want.hash_byte) begin
            $error("hash_value: expected %0d, actual %0d", want.hash_byte, hash_value);
            mismatches++;
          end
          if (owned_here !== want.owned) begin
            $error("owned_here: expected %0b, actual %0b", want.owned, owned_here);
            mismatches++;
          end
        end
      end

      // name transaction: advance the hash, predict on the last byte
      if (in_valid && in_ready) begin
        chain_hash = next_chain_hash(chain_hash, name_byte, length_mod, is_first, is_empty);
        if (is_last)
          due_digests.push_back('{hash_byte: chain_hash, owned: owns_shard(chain_hash)});
      end
    end
    outstanding = due_digests.size();
  end

endmodule

>>> verif/name_hash_shard_select_tb.sv
// ----------------------------------------------------------------------------
// name_hash_shard_select_tb - testbench top for the name hash shard selector
//
// Drives directed names (empty names, byte extremes, missing first marks,
// length mismatches, empty flags in odd places, zero and out-of-range
// cluster settings) and then phases of random names under changing cluster
// settings, with random idling on both channels. The checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module name_hash_shard_select_tb;
  import nhss_pkg::*;

  localparam int ITEM_TARGET   = 500;
  localparam int PHASES        = 8;
  localparam int SETTLE_CYCLES = 16;
  localparam int TIMEOUT_UNITS = 1_000_000;

  // Indices the block does not decode
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = CFG_INDEX_W'(3);

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_W-1:0]       cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [HASH_W-1:0]      name_byte;
  logic [HASH_W-1:0]      length_mod;
  logic                   is_first;
  logic                   is_last;
  logic                   is_empty;
  logic                   out_valid;
  logic                   out_ready;
  logic [HASH_W-1:0]      hash_value;
  logic                   owned_here;
  int                     mismatches;
  int                     outstanding;

  bit                     quiet;
  int                     items_sent;

  name_hash_shard_select DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .name_byte(name_byte), .length_mod(length_mod),
    .is_first(is_first), .is_last(is_last), .is_empty(is_empty),
    .out_valid(out_valid), .out_ready(out_ready),
    .hash_value(hash_value), .owned_here(owned_here)
  );

  name_hash_shard_select_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .name_byte(name_byte), .length_mod(length_mod),
    .is_first(is_first), .is_last(is_last), .is_empty(is_empty),
    .out_valid(out_valid), .out_ready(out_ready),
    .hash_value(hash_value), .owned_here(owned_here),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  // Clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Run limit
  initial begin
    #(TIMEOUT_UNITS);
    $display("Some tests failed");
    $finish;
  end

  // Result side: random stall bursts, none once quiet
  initial begin : sink_pacing
    int span;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(2) == 0) begin
        span = $urandom_range(14, 1);
        out_ready <= 1'b0;
        repeat (span) @(posedge clk);
      end
      span = $urandom_range(20, 1);
      out_ready <= 1'b1;
      repeat (span) @(posedge clk);
    end
  end

  // One name transaction; entered and left on a rising edge
  task automatic push_item(
    input logic [HASH_W-1:0] b,
    input logic [HASH_W-1:0] len,
    input logic              first,
    input logic              last,
    input logic              empty
  );
    int gap;
    if (!quiet && $urandom_range(3) == 0) begin
      gap = $urandom_range(14, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    name_byte  <= b;
    length_mod <= len;
    is_first   <= first;
    is_last    <= last;
    is_empty   <= empty;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    items_sent++;
  endtask

  // Hold off until every digest is back, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic set_shards(input logic [CFG_W-1:0] count, input logic [CFG_W-1:0] slot);
    write_reg(REG_CLUSTER_SIZE, count);
    write_reg(REG_CLUSTER_INDEX, slot);
    cfg_we <= 1'b0;
  endtask

  // A name of len bytes; open names never raise the last mark
  task automatic send_name(input int len, input logic [HASH_W-1:0] len_field, input bit close);
    if (len == 0) begin
      push_item(HASH_W'($urandom), len_field, 1'b1, close, 1'b1);
    end else begin
      for (int i = 0; i < len; i++) begin
        if (i > 0 && $urandom_range(9) == 0)
          push_item(HASH_W'($urandom), HASH_W'($urandom), 1'b0, 1'b0, 1'b1);
        push_item(HASH_W'($urandom), (i == 0) ? len_field : HASH_W'($urandom),
                  i == 0, close && (i == len - 1), 1'b0);
      end
    end
  endtask

  initial begin : stimulus
    int               stop_at;
    int               pick;
    int               len;
    logic [CFG_W-1:0] count;
    logic [CFG_W-1:0] slot;

    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    name_byte  = '0;
    length_mod = '0;
    is_first   = 1'b0;
    is_last    = 1'b0;
    is_empty   = 1'b0;
    quiet      = 1'b0;
    items_sent = 0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: flag corners and byte extremes
    set_shards(CFG_W'(7), CFG_W'(3));
    push_item(8'h41, 8'h00, 1'b0, 1'b1, 1'b0);   // no first mark, from the reset hash
    push_item(8'h00, 8'hff, 1'b0, 1'b1, 1'b0);   // no first mark, from the previous name
    push_item(8'h00, 8'h00, 1'b1, 1'b1, 1'b1);   // empty name
    push_item(8'hff, 8'hff, 1'b1, 1'b1, 1'b1);   // empty name, seed wraps, byte ignored
    push_item(8'h00, 8'h01, 1'b1, 1'b1, 1'b0);
    push_item(8'hff, 8'hff, 1'b1, 1'b1, 1'b0);
    push_item(8'h61, 8'h03, 1'b1, 1'b0, 1'b0);
    push_item(8'h62, 8'h03, 1'b0, 1'b0, 1'b0);
    push_item(8'h63, 8'h03, 1'b0, 1'b1, 1'b0);
    push_item(8'h01, 8'h0a, 1'b1, 1'b0, 1'b0);   // length disagrees with byte count
    push_item(8'h02, 8'h0a, 1'b0, 1'b1, 1'b0);
    push_item(8'h05, 8'h03, 1'b1, 1'b0, 1'b0);
    push_item(8'haa, 8'h03, 1'b0, 1'b0, 1'b1);   // empty flag mid-name
    push_item(8'h06, 8'h03, 1'b0, 1'b1, 1'b0);
    push_item(8'h09, 8'h00, 1'b0, 1'b1, 1'b1);   // empty flag on a last without first
    push_item(8'h09, 8'hc8, 1'b1, 1'b0, 1'b1);   // empty flag on a first that is not last
    push_item(8'h0a, 8'h00, 1'b0, 1'b1, 1'b0);
    settle();

    // Zero cluster size
    set_shards(CFG_W'(0), CFG_W'(0));
    push_item(8'h7f, 8'h04, 1'b1, 1'b1, 1'b0);
    push_item(8'h03, 8'h00, 1'b1, 1'b1, 1'b1);
    settle();

    // Index beyond size; writes to undecoded indices must not land
    write_reg(REG_CLUSTER_SIZE, CFG_W'(3));
    write_reg(REG_CLUSTER_INDEX, CFG_W'(5));
    write_reg(REG_SPARE_A, CFG_W'(0));
    write_reg(REG_SPARE_B, CFG_W'(16'hffff));
    cfg_we <= 1'b0;
    push_item(8'h80, 8'h02, 1'b1, 1'b0, 1'b0);
    push_item(8'h55, 8'h02, 1'b0, 1'b1, 1'b0);
    settle();

    // Widest settings
    set_shards(CFG_W'(16'hffff), CFG_W'(16'hfffe));
    push_item(8'h33, 8'h01, 1'b1, 1'b1, 1'b0);
    push_item(8'hcc, 8'h00, 1'b1, 1'b1, 1'b1);
    settle();

    // Random phases, one cluster setting each
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == PHASES - 1) quiet = 1'b1;
      case ($urandom_range(5))
        0: begin
          count = CFG_W'(16'hffff);
          slot  = ($urandom_range(1) == 0) ? CFG_W'(16'hfffe) : CFG_W'(0);
        end
        1: begin
          count = CFG_W'(0);
          slot  = CFG_W'($urandom_range(16'hffff));
        end
        2: begin
          count = CFG_W'($urandom_range(16'hffff));
          slot  = CFG_W'($urandom_range(16'hffff));
        end
        3: begin
          count = CFG_W'($urandom_range(256, 17));
          slot  = CFG_W'($urandom_range(count - 1));
        end
        default: begin
          count = CFG_W'($urandom_range(16, 1));
          slot  = CFG_W'($urandom_range(count - 1));
        end
      endcase
      if (phase == 0) begin
        count = CLUSTER_SIZE_RESET;
        slot  = CLUSTER_INDEX_RESET;
      end
      set_shards(count, slot);

      stop_at = items_sent + ITEM_TARGET / PHASES;
      while (items_sent < stop_at) begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          // noise: every field random
          push_item(HASH_W'($urandom), HASH_W'($urandom), 1'($urandom), 1'($urandom),
                    1'($urandom));
        end else if (pick < 12) begin
          // continuation without a first mark
          push_item(HASH_W'($urandom), HASH_W'($urandom), 1'b0, 1'($urandom), 1'b0);
        end else if (pick < 16) begin
          // name cut short, never closed
          send_name($urandom_range(4, 1), HASH_W'($urandom), 1'b0);
        end else begin
          len = ($urandom_range(9) == 0) ? $urandom_range(40, 7) : $urandom_range(6, 0);
          send_name(len, ($urandom_range(7) == 0) ? HASH_W'($urandom) : HASH_W'(len), 1'b1);
        end
      end
      settle();
    end

    if (mismatches == 0 && outstanding == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

>>> files.f
hdl/nhss_pkg.sv
hdl/nhss_ram.sv
hdl/nhss_perm_build.sv
hdl/nhss_rem.sv
hdl/name_hash_shard_select.sv
hdl/nhss_checker.sv
verif/name_hash_shard_select_checker.sv
verif/name_hash_shard_select_tb.sv
